>>> hw/rtl/swbm_pkg.sv
// Shared constants and types for the sliding window best match unit.
package swbm_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 32;
  localparam longint unsigned TEXT_MAX_DEF = 64'd65536;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned LEN_W   = 6;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  // Per-cell controls, driven by the top level every cycle.
  typedef struct packed {
    logic             load;
    logic             shift;
    logic [SYM_W-1:0] symbol;
  } swbm_cell_ctl_t;

endpackage

>>> hw/rtl/swbm_cell.sv
// One cell of the scoring chain: a pattern byte and the running score of one alignment.
module swbm_cell #(
  parameter int unsigned SW = 6
) (
  input  logic                    clk,
  input  swbm_pkg::swbm_cell_ctl_t ctl,
  input  logic [SW-1:0]           score_in,
  output logic [SW-1:0]           score_sum,
  output logic [SW-1:0]           score_out
);
  import swbm_pkg::*;

  logic [SYM_W-1:0] pat;
  logic [SW-1:0]    score;

  assign score_sum = score_in + SW'(pat == ctl.symbol);
  assign score_out = score;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pat <= ctl.symbol;
    end
    if (ctl.shift) begin
      score <= score_sum;
    end
  end

endmodule

>>> hw/rtl/sliding_window_best_match_unit.sv
// Top level of the sliding window best match unit: cell chain, best tracking and result register.
// Pattern bytes (mode 0) and text bytes (mode 1) share one input; the unit sustains one byte per
// clock unless the input is stalled. A row of PATTERN_MAX cells holds the pattern; on every text
// byte each cell compares its pattern byte with the incoming byte and passes its running score
// to the next cell, so the alignment that ends at this byte has its finished count at the cell
// indexed by the pattern length minus one. The result of a text byte marked last is registered
// and shown on the next cycle; input is stalled only when a further last text byte arrives while
// that result has not yet been taken. No clearing pass is needed after reset.
module sliding_window_best_match_unit #(
  parameter int unsigned     PATTERN_MAX = swbm_pkg::PATTERN_MAX_DEF,
  parameter longint unsigned TEXT_MAX    = swbm_pkg::TEXT_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [swbm_pkg::SYM_W-1:0]    symbol,
  input  logic                          first,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [swbm_pkg::COUNT_W-1:0]  matched_count,
  output logic [swbm_pkg::POS_W-1:0]    position,
  output logic [swbm_pkg::LEN_W-1:0]    match_length,
  output logic                          overflow
);
  import swbm_pkg::*;

  localparam int unsigned SW   = $clog2(PATTERN_MAX + 1);
  localparam int unsigned LW   = $clog2(PATTERN_MAX + 1);
  localparam int unsigned IW   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned TCW  = $clog2(TEXT_MAX + 1);
  localparam int unsigned CMPW = ((TCW > LW) ? TCW : LW) + 1;
  localparam logic [TCW-1:0] TEXT_LIMIT = TCW'(TEXT_MAX);
  localparam logic [LW-1:0]  LEN_LIMIT  = LW'(PATTERN_MAX);

  logic [LW-1:0]    len;
  logic [TCW-1:0]   text_count;
  logic [SW-1:0]    best;
  logic [POS_W-1:0] best_pos;
  logic             ovf;

  logic [LW-1:0]    len_next;
  logic [TCW-1:0]   text_count_next;
  logic [SW-1:0]    best_next;
  logic [POS_W-1:0] best_pos_next;
  logic             ovf_next;

  logic             accept;
  logic             pat_acc;
  logic             txt_acc;
  logic [LW-1:0]    wr_idx;
  logic             wr_ok;
  logic [TCW-1:0]   t_cur;
  logic [SW-1:0]    best_cur;
  logic [POS_W-1:0] pos_cur;
  logic             ovf_cur;
  logic             in_range;
  logic             done;
  logic [IW-1:0]    tail_idx;
  logic [SW-1:0]    tail_score;
  logic [CMPW-1:0]  start;
  logic             res_found;

  swbm_cell_ctl_t   ctl   [PATTERN_MAX];
  logic [SW-1:0]    sums  [PATTERN_MAX];
  logic [SW-1:0]    chain [PATTERN_MAX];

  // A last text byte may not overwrite a result that is still waiting.
  assign in_ready = !out_valid || out_ready || !(mode == MODE_TEXT && last);
  assign accept   = in_valid && in_ready;
  assign pat_acc  = accept && (mode == MODE_PATTERN);
  assign txt_acc  = accept && (mode == MODE_TEXT);

  assign wr_idx = first ? '0 : len;
  assign wr_ok  = wr_idx < LEN_LIMIT;

  // Text state as seen by this byte: a first byte starts from a clean slate.
  assign t_cur    = first ? '0 : text_count;
  assign best_cur = first ? '0 : best;
  assign pos_cur  = first ? '0 : best_pos;
  assign ovf_cur  = first ? 1'b0 : ovf;
  assign in_range = t_cur != TEXT_LIMIT;

  genvar k;
  generate
    for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [SW-1:0] score_in;
      if (k == 0) begin : g_head
        assign score_in = '0;
      end else begin : g_link
        assign score_in = chain[k-1];
      end
      assign ctl[k].load   = pat_acc && wr_ok && (wr_idx == LW'(k));
      assign ctl[k].shift  = txt_acc && in_range;
      assign ctl[k].symbol = symbol;
      swbm_cell #(.SW(SW)) u_cell (
        .clk       (clk),
        .ctl       (ctl[k]),
        .score_in  (score_in),
        .score_sum (sums[k]),
        .score_out (chain[k])
      );
    end
  endgenerate

  assign tail_idx   = IW'(len - LW'(1));
  assign tail_score = sums[tail_idx];
  // An alignment completes once the text holds at least as many bytes as the pattern.
  assign done  = (len != '0) && in_range &&
                 (CMPW'(t_cur) + CMPW'(1) >= CMPW'(len));
  assign start = CMPW'(t_cur) + CMPW'(1) - CMPW'(len);

  always_comb begin
    len_next        = len;
    text_count_next = text_count;
    best_next       = best;
    best_pos_next   = best_pos;
    ovf_next        = ovf;
    if (pat_acc) begin
      text_count_next = '0;
      best_next       = '0;
      best_pos_next   = '0;
      ovf_next        = 1'b0;
      if (wr_ok) begin
        len_next = wr_idx + LW'(1);
      end else begin
        len_next = wr_idx;
      end
    end else if (txt_acc) begin
      text_count_next = in_range ? t_cur + TCW'(1) : t_cur;
      ovf_next        = ovf_cur || !in_range;
      best_next       = best_cur;
      best_pos_next   = pos_cur;
      if (done && (tail_score > best_cur)) begin
        best_next     = tail_score;
        best_pos_next = POS_W'(start);
      end
    end
  end

  assign res_found = best_next != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      text_count <= '0;
      best       <= '0;
      best_pos   <= '0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      len <= len_next;
      if (txt_acc && last) begin
        text_count <= '0;
        best       <= '0;
        best_pos   <= '0;
        ovf        <= 1'b0;
        out_valid  <= 1'b1;
      end else begin
        text_count <= text_count_next;
        best       <= best_next;
        best_pos   <= best_pos_next;
        ovf        <= ovf_next;
        if (out_ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (txt_acc && last) begin
      found         <= res_found;
      matched_count <= res_found ? COUNT_W'(best_next) : '0;
      position      <= res_found ? best_pos_next : '0;
      match_length  <= res_found ? LEN_W'(len) : '0;
      overflow      <= ovf_next;
    end
  end

endmodule

>>> hw/rtl/swbm_checker.sv
// Port-level checks for the sliding window best match unit, bound to the top level.
module swbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          mode,
  input logic                          last,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          found,
  input logic [swbm_pkg::COUNT_W-1:0]  matched_count,
  input logic [swbm_pkg::POS_W-1:0]    position,
  input logic [swbm_pkg::LEN_W-1:0]    match_length
);
  import swbm_pkg::*;

  // A result without a match carries all-zero fields.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (matched_count == '0 && position == '0 && match_length == '0))
    else $error("result without a match has non-zero fields");

  // A new result only follows an accepted last text byte.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && !out_ready)) |->
      $past(in_valid && in_ready && mode == MODE_TEXT && last))
    else $error("result raised without a final text transaction");

  // A pending result must not be overwritten by another final text byte.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && in_valid && mode == MODE_TEXT && last) |-> !in_ready)
    else $error("final text byte accepted while a result was stalled");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(found) && $stable(matched_count) && $stable(position)))
    else $error("stalled result changed");

endmodule

bind sliding_window_best_match_unit swbm_checker u_swbm_checker (.*);

>>> tb/tb_sliding_window_best_match_unit.sv
// Self-checking testbench for the sliding window best match unit with a built-in score predictor.
`timescale 1ns / 100ps

module tb_sliding_window_best_match_unit;
  import swbm_pkg::*;

  localparam int unsigned PAT_DEPTH   = PATTERN_MAX_DEF;
  localparam int unsigned TEXT_LIMIT  = 32'(TEXT_MAX_DEF);
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic               found;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   pos;
    logic [LEN_W-1:0]   len;
    logic               ovf;
  } match_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               mode;
  logic [SYM_W-1:0]   symbol;
  logic               first;
  logic               last;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               found;
  logic [COUNT_W-1:0] matched_count;
  logic [POS_W-1:0]   position;
  logic [LEN_W-1:0]   match_length;
  logic               overflow;

  // Predictor state.
  logic [SYM_W-1:0] pat_mem [PAT_DEPTH];
  int unsigned      pat_len;
  int unsigned      score_mem [PAT_DEPTH];
  int unsigned      txt_count;
  int unsigned      best_score;
  int unsigned      best_start;
  logic             txt_overflow;

  match_result_t    pending_results [$];
  int unsigned      error_count;
  int unsigned      cycle_count;
  int unsigned      sender_idle;
  int unsigned      stall_pct;
  logic [SYM_W-1:0] sym_base;
  logic [SYM_W-1:0] sym_mask;

  sliding_window_best_match_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .symbol        (symbol),
    .first         (first),
    .last          (last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .matched_count (matched_count),
    .position      (position),
    .match_length  (match_length),
    .overflow      (overflow)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void clear_text_state();
    for (int k = 0; k < PAT_DEPTH; k++) begin
      score_mem[k] = 0;
    end
    txt_count    = 0;
    best_score   = 0;
    best_start   = 0;
    txt_overflow = 1'b0;
  endfunction

  // Every open alignment keeps its running score in the slot of its start offset.
  function automatic void score_text_byte(input logic [SYM_W-1:0] s);
    int unsigned start;
    int unsigned slot;
    if (txt_count >= TEXT_LIMIT) begin
      txt_overflow = 1'b1;
      return;
    end
    for (int unsigned j = 0; j < pat_len; j++) begin
      if (txt_count < j) break;
      start = txt_count - j;
      slot  = start % PAT_DEPTH;
      if (j == 0) score_mem[slot] = 0;
      if (pat_mem[j] == s) score_mem[slot]++;
      if (j + 1 == pat_len && score_mem[slot] > best_score) begin
        best_score = score_mem[slot];
        best_start = start;
      end
    end
    txt_count++;
  endfunction

  function automatic void advance_matcher(input logic m, input logic [SYM_W-1:0] s,
                                          input logic f, input logic l);
    match_result_t res;
    if (m == MODE_PATTERN) begin
      clear_text_state();
      if (f) pat_len = 0;
      if (pat_len < PAT_DEPTH) begin
        pat_mem[pat_len] = s;
        pat_len++;
      end
      return;
    end
    if (f) clear_text_state();
    score_text_byte(s);
    if (!l) return;
    res.found = (best_score > 0);
    res.count = res.found ? best_score[COUNT_W-1:0] : '0;
    res.pos   = res.found ? best_start[POS_W-1:0] : '0;
    res.len   = res.found ? pat_len[LEN_W-1:0] : '0;
    res.ovf   = txt_overflow;
    pending_results = {pending_results, res};
    clear_text_state();
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    match_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%0d count=%0d pos=%0d",
                 $time, found, matched_count, position);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("found", exp_r.found, found);
        check_field("matched_count", exp_r.count, matched_count);
        check_field("position", exp_r.pos, position);
        check_field("match_length", exp_r.len, match_length);
        check_field("overflow", exp_r.ovf, overflow);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_byte(input logic m, input logic [SYM_W-1:0] s, input logic f,
                           input logic l);
    while ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    symbol   <= s;
    first    <= f;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_matcher(m, s, f, l);
    @(negedge clk);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    return sym_base ^ (SYM_W'($urandom) & (($urandom_range(15) == 0) ? 8'hFF : sym_mask));
  endfunction

  task automatic test_empty_pattern();
    send_byte(MODE_TEXT, 8'h00, 1'b1, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b1);
  endtask

  // A last flag on a pattern byte must not produce a result; equal scores keep the earliest.
  task automatic test_pattern_and_ties();
    send_byte(MODE_PATTERN, 8'h00, 1'b1, 1'b1);
    send_byte(MODE_PATTERN, 8'hFF, 1'b0, 1'b0);
    send_byte(MODE_PATTERN, 8'h5A, 1'b0, 1'b1);
    send_byte(MODE_TEXT, 8'h00, 1'b1, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b1);
    send_byte(MODE_TEXT, 8'h00, 1'b1, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h5A, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h00, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h5A, 1'b0, 1'b1);
    send_byte(MODE_TEXT, 8'h11, 1'b1, 1'b0);
    send_byte(MODE_TEXT, 8'h22, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h33, 1'b0, 1'b1);
    send_byte(MODE_TEXT, 8'h5A, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h00, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h5A, 1'b0, 1'b1);
  endtask

  // A pattern byte abandons the text in progress; a first flag restarts a text.
  task automatic test_abandon_and_restart();
    send_byte(MODE_TEXT, 8'h00, 1'b1, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b0);
    send_byte(MODE_PATTERN, 8'h77, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h00, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h5A, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h77, 1'b1, 1'b0);
    send_byte(MODE_TEXT, 8'h00, 1'b1, 1'b0);
    send_byte(MODE_TEXT, 8'hFF, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h5A, 1'b0, 1'b0);
    send_byte(MODE_TEXT, 8'h77, 1'b0, 1'b1);
  endtask

  // Bytes past the pattern capacity are dropped.
  task automatic test_pattern_full();
    for (int k = 0; k < PAT_DEPTH + 3; k++) begin
      send_byte(MODE_PATTERN, 8'(k * 7), k == 0, 1'b0);
    end
    for (int k = 0; k < PAT_DEPTH + 2; k++) begin
      send_byte(MODE_TEXT, 8'(k * 7), k == 0, k == PAT_DEPTH + 1);
    end
  endtask

  // Mostly well-formed pattern loads and texts over a narrow alphabet, with some noise.
  task automatic test_random_sessions(input int unsigned idle, input int unsigned stall,
                                      input int unsigned items);
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    sender_idle = idle;
    stall_pct   = stall;
    sent        = 0;
    while (sent < items) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        n        = ($urandom_range(9) == 0) ? $urandom_range(1, PAT_DEPTH + 4)
                                            : $urandom_range(1, 8);
        sym_base = 8'($urandom);
        case ($urandom_range(2))
          0: sym_mask = 8'h01;
          1: sym_mask = 8'h03;
          default: sym_mask = 8'h07;
        endcase
        for (int unsigned k = 0; k < n; k++) begin
          send_byte(MODE_PATTERN, pick_symbol(), k == 0, $urandom_range(7) == 0);
        end
        sent += n;
      end else if (kind < 88) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
        for (int unsigned k = 0; k < n; k++) begin
          send_byte(MODE_TEXT, pick_symbol(),
                    (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
                    k == n - 1);
        end
        sent += n;
      end else begin
        send_byte(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_PATTERN;
    symbol       = '0;
    first        = 1'b0;
    last         = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    sender_idle  = 0;
    stall_pct    = 0;
    sym_base     = '0;
    sym_mask     = 8'h03;
    for (int k = 0; k < PAT_DEPTH; k++) begin
      pat_mem[k] = '0;
    end
    pat_len = 0;
    clear_text_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_pattern();
    stall_pct = 40;
    test_pattern_and_ties();
    test_abandon_and_restart();
    test_pattern_full();
    stall_pct = 0;
    test_random_sessions(0, 0, 325);
    test_random_sessions(54, 0, 325);
    test_random_sessions(0, 54, 325);
    test_random_sessions(9, 9, 325);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/swbm_pkg.sv
hw/rtl/swbm_cell.sv
hw/rtl/sliding_window_best_match_unit.sv
hw/rtl/swbm_checker.sv
tb/tb_sliding_window_best_match_unit.sv
